FILE: src/vru_pkg.sv
// Shared widths, types and arithmetic helpers of the vector refraction unit.
package vru_pkg;

    // Fixed-point format of all inputs and results.
    localparam int FRAC_BITS = 14;
    localparam int W_IN      = 16;
    localparam int W_OUT     = 20;

    // Widths of the intermediate values along the datapath.
    localparam int W_PROD = 2 * W_IN;               // v*n product
    localparam int W_DOT  = W_PROD + 2;             // sum of three products
    localparam int W_D    = W_DOT - FRAC_BITS;      // d = floor(dot)
    localparam int W_DD   = 2 * W_D;                // d*d
    localparam int W_T    = W_DD - FRAC_BITS + 1;   // t = ONE - floor(d*d)
    localparam int W_EE   = 2 * W_IN;               // eta*eta
    localparam int W_E2   = W_EE - FRAC_BITS;       // e2 = floor(eta*eta)
    localparam int W_ET   = W_E2 + 1 + W_T;         // e2*t
    localparam int W_K    = W_ET - FRAC_BITS + 1;   // k = ONE - floor(e2*t)
    localparam int W_S    = 20;                     // root width; k stays below 2^26
    localparam int W_X    = 2 * W_S;                // radicand k << FRAC_BITS
    localparam int W_REM  = W_S + 4;                // partial remainder of the root
    localparam int W_EDF  = W_IN + 1 + W_D;         // eta*d
    localparam int W_ED   = W_EDF - FRAC_BITS;      // floor(eta*d)
    localparam int W_C    = W_ED + 1;               // c = floor(eta*d) + s
    localparam int W_CN   = W_C + W_IN;             // c*n
    localparam int W_EV   = 2 * W_IN + 1;           // eta*v
    localparam int W_DIFF = W_CN + 1;               // eta*v - c*n
    localparam int W_F    = W_DIFF - FRAC_BITS;     // floor of the difference

    // The root resolves two result bits per pipeline stage.
    localparam int SQ_STAGES = W_S / 2;

    localparam logic signed [W_T-1:0] ONE_T = W_T'(2 ** FRAC_BITS);
    localparam logic signed [W_K-1:0] ONE_K = W_K'(2 ** FRAC_BITS);

    localparam logic signed [W_F-1:0] F_MAX = W_F'(2 ** (W_OUT - 1) - 1);
    localparam logic signed [W_F-1:0] F_MIN = ~F_MAX;

    // Working state of the digit-by-digit square root.
    typedef struct packed {
        logic [W_X-1:0]   x;
        logic [W_REM-1:0] rem;
        logic [W_S-1:0]   root;
    } t_sq;

    // Operands that ride alongside the square root until the back end.
    typedef struct packed {
        logic signed [W_EV-1:0] ev_x;
        logic signed [W_EV-1:0] ev_y;
        logic signed [W_EV-1:0] ev_z;
        logic signed [W_IN-1:0] n_x;
        logic signed [W_IN-1:0] n_y;
        logic signed [W_IN-1:0] n_z;
        logic signed [W_ED-1:0] ed;
        logic                   tir;
    } t_side;

    // One restoring step of the integer square root: brings in two radicand bits
    // and decides one root bit.
    function automatic t_sq sq_step(input t_sq a);
        logic [W_REM-1:0] rem2;
        logic [W_REM-1:0] trial;
        t_sq              b;
        rem2  = {a.rem[W_REM-3:0], a.x[W_X-1 -: 2]};
        trial = W_REM'({a.root, 2'b01});
        b.x   = {a.x[W_X-3:0], 2'b00};
        if (rem2 >= trial) begin
            b.rem  = rem2 - trial;
            b.root = {a.root[W_S-2:0], 1'b1};
        end else begin
            b.rem  = rem2;
            b.root = {a.root[W_S-2:0], 1'b0};
        end
        return b;
    endfunction

    // Clamps a floored component to the signed output range.
    function automatic logic signed [W_OUT-1:0] sat_out(input logic signed [W_F-1:0] f);
        logic signed [W_F-1:0] g;
        g = f;
        if (f > F_MAX) begin
            g = F_MAX;
        end else if (f < F_MIN) begin
            g = F_MIN;
        end
        return g[W_OUT-1:0];
    endfunction

endpackage

FILE: src/vru_front.sv
// Front pipeline: dot product, d squared, eta squared and the discriminant k.
module vru_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_x,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_y,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_z,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_x,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_y,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_z,
    input  logic        [vru_pkg::W_IN-1:0]      i_index_ratio,
    output logic                                 o_valid,
    output vru_pkg::t_sq                         o_sq,
    output vru_pkg::t_side                       o_side
);
    import vru_pkg::*;

    // Stage 1 registers: products of the raw inputs.
    logic                   r1_valid;
    logic signed [W_PROD-1:0] r1_vn_x, r1_vn_y, r1_vn_z;
    logic        [W_EE-1:0] r1_ee;
    logic signed [W_EV-1:0] r1_ev_x, r1_ev_y, r1_ev_z;
    logic signed [W_IN-1:0] r1_n_x, r1_n_y, r1_n_z;
    logic        [W_IN-1:0] r1_eta;

    // Stage 2 registers: d and e2.
    logic                   r2_valid;
    logic signed [W_D-1:0]  r2_d;
    logic        [W_E2-1:0] r2_e2;
    logic signed [W_EV-1:0] r2_ev_x, r2_ev_y, r2_ev_z;
    logic signed [W_IN-1:0] r2_n_x, r2_n_y, r2_n_z;
    logic        [W_IN-1:0] r2_eta;

    // Stage 3 registers: d*d and eta*d.
    logic                    r3_valid;
    logic signed [W_DD-1:0]  r3_dd;
    logic signed [W_EDF-1:0] r3_edf;
    logic        [W_E2-1:0]  r3_e2;
    logic signed [W_EV-1:0]  r3_ev_x, r3_ev_y, r3_ev_z;
    logic signed [W_IN-1:0]  r3_n_x, r3_n_y, r3_n_z;

    // Stage 4 registers: t.
    logic                   r4_valid;
    logic signed [W_T-1:0]  r4_t;
    logic        [W_E2-1:0] r4_e2;
    logic signed [W_ED-1:0] r4_ed;
    logic signed [W_EV-1:0] r4_ev_x, r4_ev_y, r4_ev_z;
    logic signed [W_IN-1:0] r4_n_x, r4_n_y, r4_n_z;

    // Stage 5 registers: e2*t.
    logic                   r5_valid;
    logic signed [W_ET-1:0] r5_et;
    logic signed [W_ED-1:0] r5_ed;
    logic signed [W_EV-1:0] r5_ev_x, r5_ev_y, r5_ev_z;
    logic signed [W_IN-1:0] r5_n_x, r5_n_y, r5_n_z;

    // Stage 6 registers: radicand and side operands.
    logic  r6_valid;
    t_sq   r6_sq;
    t_side r6_side;

    logic signed [W_PROD-1:0] n1_vn_x, n1_vn_y, n1_vn_z;
    logic        [W_EE-1:0]   n1_ee;
    logic signed [W_EV-1:0]   n1_ev_x, n1_ev_y, n1_ev_z;
    logic signed [W_DOT-1:0]  n2_dot;
    logic signed [W_DD-1:0]   n3_dd;
    logic signed [W_EDF-1:0]  n3_edf;
    logic signed [W_T-1:0]    n4_t;
    logic signed [W_ET-1:0]   n5_et;
    logic signed [W_K-1:0]    n6_k;
    logic                     n6_tir;

    // Stage 1: the three v*n products, eta*eta and eta*v.
    always_comb begin
        n1_vn_x = i_inc_x * i_norm_x;
        n1_vn_y = i_inc_y * i_norm_y;
        n1_vn_z = i_inc_z * i_norm_z;
        n1_ee   = i_index_ratio * i_index_ratio;
        n1_ev_x = $signed({1'b0, i_index_ratio}) * i_inc_x;
        n1_ev_y = $signed({1'b0, i_index_ratio}) * i_inc_y;
        n1_ev_z = $signed({1'b0, i_index_ratio}) * i_inc_z;
    end

    // Stage 2: sum of products; floor is the upper bits.
    always_comb begin
        n2_dot = r1_vn_x + r1_vn_y + r1_vn_z;
    end

    // Stage 3: d squared and eta times d.
    always_comb begin
        n3_dd  = r2_d * r2_d;
        n3_edf = $signed({1'b0, r2_eta}) * r2_d;
    end

    // Stage 4: t = ONE - floor(d*d).
    always_comb begin
        n4_t = ONE_T - $signed({r3_dd[W_DD-1], r3_dd[W_DD-1:FRAC_BITS]});
    end

    // Stage 5: e2 times t.
    always_comb begin
        n5_et = $signed({1'b0, r4_e2}) * r4_t;
    end

    // Stage 6: k and the total internal reflection flag.
    always_comb begin
        n6_k   = ONE_K - $signed({r5_et[W_ET-1], r5_et[W_ET-1:FRAC_BITS]});
        n6_tir = n6_k[W_K-1];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // Payload registers of all six stages.
    always_ff @(posedge i_clk) begin
        r1_vn_x <= n1_vn_x;
        r1_vn_y <= n1_vn_y;
        r1_vn_z <= n1_vn_z;
        r1_ee   <= n1_ee;
        r1_ev_x <= n1_ev_x;
        r1_ev_y <= n1_ev_y;
        r1_ev_z <= n1_ev_z;
        r1_n_x  <= i_norm_x;
        r1_n_y  <= i_norm_y;
        r1_n_z  <= i_norm_z;
        r1_eta  <= i_index_ratio;

        r2_d    <= n2_dot[W_DOT-1:FRAC_BITS];
        r2_e2   <= r1_ee[W_EE-1:FRAC_BITS];
        r2_ev_x <= r1_ev_x;
        r2_ev_y <= r1_ev_y;
        r2_ev_z <= r1_ev_z;
        r2_n_x  <= r1_n_x;
        r2_n_y  <= r1_n_y;
        r2_n_z  <= r1_n_z;
        r2_eta  <= r1_eta;

        r3_dd   <= n3_dd;
        r3_edf  <= n3_edf;
        r3_e2   <= r2_e2;
        r3_ev_x <= r2_ev_x;
        r3_ev_y <= r2_ev_y;
        r3_ev_z <= r2_ev_z;
        r3_n_x  <= r2_n_x;
        r3_n_y  <= r2_n_y;
        r3_n_z  <= r2_n_z;

        r4_t    <= n4_t;
        r4_e2   <= r3_e2;
        r4_ed   <= r3_edf[W_EDF-1:FRAC_BITS];
        r4_ev_x <= r3_ev_x;
        r4_ev_y <= r3_ev_y;
        r4_ev_z <= r3_ev_z;
        r4_n_x  <= r3_n_x;
        r4_n_y  <= r3_n_y;
        r4_n_z  <= r3_n_z;

        r5_et   <= n5_et;
        r5_ed   <= r4_ed;
        r5_ev_x <= r4_ev_x;
        r5_ev_y <= r4_ev_y;
        r5_ev_z <= r4_ev_z;
        r5_n_x  <= r4_n_x;
        r5_n_y  <= r4_n_y;
        r5_n_z  <= r4_n_z;

        // A negative k gives a zero radicand; its result is forced to zero later.
        r6_sq.x      <= n6_tir ? '0 : {n6_k[W_X-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        r6_sq.rem    <= '0;
        r6_sq.root   <= '0;
        r6_side.ev_x <= r5_ev_x;
        r6_side.ev_y <= r5_ev_y;
        r6_side.ev_z <= r5_ev_z;
        r6_side.n_x  <= r5_n_x;
        r6_side.n_y  <= r5_n_y;
        r6_side.n_z  <= r5_n_z;
        r6_side.ed   <= r5_ed;
        r6_side.tir  <= n6_tir;
    end

    assign o_valid = r6_valid;
    assign o_sq    = r6_sq;
    assign o_side  = r6_side;

endmodule

FILE: src/vru_sqrt_stage.sv
// One pipeline stage of the square root, resolving two root bits.
module vru_sqrt_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vru_pkg::t_sq   i_sq,
    input  vru_pkg::t_side i_side,
    output logic           o_valid,
    output vru_pkg::t_sq   o_sq,
    output vru_pkg::t_side o_side
);
    import vru_pkg::*;

    logic  r_valid;
    t_sq   r_sq;
    t_side r_side;
    t_sq   n_sq;

    // Two dependent restoring steps.
    always_comb begin
        n_sq = sq_step(sq_step(i_sq));
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Root state and side operands.
    always_ff @(posedge i_clk) begin
        r_sq   <= n_sq;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_side  = r_side;

endmodule

FILE: src/vru_back.sv
// Back pipeline: c, c*n, eta*v - c*n, floor and saturation of the result.
module vru_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic        [vru_pkg::W_S-1:0]        i_root,
    input  vru_pkg::t_side                        i_side,
    output logic                                  o_strobe,
    output logic signed [vru_pkg::W_OUT-1:0]      o_out_x,
    output logic signed [vru_pkg::W_OUT-1:0]      o_out_y,
    output logic signed [vru_pkg::W_OUT-1:0]      o_out_z,
    output logic                                  o_total_reflect
);
    import vru_pkg::*;

    // Stage 1 registers: c.
    logic                   r1_valid;
    logic signed [W_C-1:0]  r1_c;
    logic signed [W_EV-1:0] r1_ev_x, r1_ev_y, r1_ev_z;
    logic signed [W_IN-1:0] r1_n_x, r1_n_y, r1_n_z;
    logic                   r1_tir;

    // Stage 2 registers: c*n.
    logic                   r2_valid;
    logic signed [W_CN-1:0] r2_cn_x, r2_cn_y, r2_cn_z;
    logic signed [W_EV-1:0] r2_ev_x, r2_ev_y, r2_ev_z;
    logic                   r2_tir;

    // Stage 3 registers: the result transaction.
    logic                    r3_valid;
    logic signed [W_OUT-1:0] r3_x, r3_y, r3_z;
    logic                    r3_tir;

    logic signed [W_C-1:0]    n1_c;
    logic signed [W_CN-1:0]   n2_cn_x, n2_cn_y, n2_cn_z;
    logic signed [W_DIFF-1:0] n3_diff_x, n3_diff_y, n3_diff_z;
    logic signed [W_OUT-1:0]  n3_x, n3_y, n3_z;

    // Stage 1: c = floor(eta*d) + root.
    always_comb begin
        n1_c = $signed({{(W_C - W_ED){i_side.ed[W_ED-1]}}, i_side.ed})
             + $signed({{(W_C - W_S){1'b0}}, i_root});
    end

    // Stage 2: c times each normal component.
    always_comb begin
        n2_cn_x = r1_c * r1_n_x;
        n2_cn_y = r1_c * r1_n_y;
        n2_cn_z = r1_c * r1_n_z;
    end

    // Stage 3: difference, floor, saturate; zero on total internal reflection.
    always_comb begin
        n3_diff_x = r2_ev_x - r2_cn_x;
        n3_diff_y = r2_ev_y - r2_cn_y;
        n3_diff_z = r2_ev_z - r2_cn_z;
        n3_x = r2_tir ? '0 : sat_out(n3_diff_x[W_DIFF-1:FRAC_BITS]);
        n3_y = r2_tir ? '0 : sat_out(n3_diff_y[W_DIFF-1:FRAC_BITS]);
        n3_z = r2_tir ? '0 : sat_out(n3_diff_z[W_DIFF-1:FRAC_BITS]);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r1_c    <= n1_c;
        r1_ev_x <= i_side.ev_x;
        r1_ev_y <= i_side.ev_y;
        r1_ev_z <= i_side.ev_z;
        r1_n_x  <= i_side.n_x;
        r1_n_y  <= i_side.n_y;
        r1_n_z  <= i_side.n_z;
        r1_tir  <= i_side.tir;

        r2_cn_x <= n2_cn_x;
        r2_cn_y <= n2_cn_y;
        r2_cn_z <= n2_cn_z;
        r2_ev_x <= r1_ev_x;
        r2_ev_y <= r1_ev_y;
        r2_ev_z <= r1_ev_z;
        r2_tir  <= r1_tir;

        r3_x    <= n3_x;
        r3_y    <= n3_y;
        r3_z    <= n3_z;
        r3_tir  <= r2_tir;
    end

    assign o_strobe        = r3_valid;
    assign o_out_x         = r3_x;
    assign o_out_y         = r3_y;
    assign o_out_z         = r3_z;
    assign o_total_reflect = r3_tir;

endmodule

FILE: src/vector_refraction_unit.sv
// Pipeline: 6 front stages, 10 square-root stages at two root bits each, 3 back stages;
// the result strobe comes from the last back stage.
// Throughput: one transaction per cycle; busy is always low since the pipeline
// never stalls and the receiver takes every result in its strobe cycle.
// Reset (synchronous, active low) clears only the valid bits of the pipeline;
// transactions in flight at reset are dropped.
module vector_refraction_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_x,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_y,
    input  logic signed [vru_pkg::W_IN-1:0]      i_inc_z,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_x,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_y,
    input  logic signed [vru_pkg::W_IN-1:0]      i_norm_z,
    input  logic        [vru_pkg::W_IN-1:0]      i_index_ratio,
    output logic                                 o_strobe,
    output logic signed [vru_pkg::W_OUT-1:0]     o_out_x,
    output logic signed [vru_pkg::W_OUT-1:0]     o_out_y,
    output logic signed [vru_pkg::W_OUT-1:0]     o_out_z,
    output logic                                 o_total_reflect
);
    import vru_pkg::*;

    logic  w_valid [SQ_STAGES+1];
    t_sq   w_sq    [SQ_STAGES+1];
    t_side w_side  [SQ_STAGES+1];

    // The pipeline always takes a new transaction.
    assign busy = 1'b0;

    // Dot product through discriminant.
    vru_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_inc_x       (i_inc_x),
        .i_inc_y       (i_inc_y),
        .i_inc_z       (i_inc_z),
        .i_norm_x      (i_norm_x),
        .i_norm_y      (i_norm_y),
        .i_norm_z      (i_norm_z),
        .i_index_ratio (i_index_ratio),
        .o_valid       (w_valid[0]),
        .o_sq          (w_sq[0]),
        .o_side        (w_side[0])
    );

    // Square-root pipeline.
    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
        vru_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_sq    (w_sq[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_sq    (w_sq[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Result assembly.
    vru_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid[SQ_STAGES]),
        .i_root          (w_sq[SQ_STAGES].root),
        .i_side          (w_side[SQ_STAGES]),
        .o_strobe        (o_strobe),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_total_reflect (o_total_reflect)
    );

endmodule

FILE: bench/vector_refraction_unit_tb.sv
// Self-checking testbench for the vector refraction unit with a fixed-point refraction predictor.
`timescale 1ns / 1ps

module vector_refraction_unit_tb;
    import vru_pkg::*;

    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES  = 25;
    localparam int  RANDOM_ITEMS  = 1100;
    localparam int  PHASE_COUNT   = 4;
    localparam int  Q_ONE         = 1 << FRAC_BITS;
    localparam longint OUT_HI     = (64'sd1 <<< (W_OUT - 1)) - 1;
    localparam longint OUT_LO     = -(64'sd1 <<< (W_OUT - 1));

    // One incident ray with its surface normal and index ratio.
    typedef struct packed {
        logic signed [W_IN-1:0] inc_x;
        logic signed [W_IN-1:0] inc_y;
        logic signed [W_IN-1:0] inc_z;
        logic signed [W_IN-1:0] norm_x;
        logic signed [W_IN-1:0] norm_y;
        logic signed [W_IN-1:0] norm_z;
        logic        [W_IN-1:0] eta;
    } t_ray_in;

    // One refracted direction.
    typedef struct packed {
        logic signed [W_OUT-1:0] out_x;
        logic signed [W_OUT-1:0] out_y;
        logic signed [W_OUT-1:0] out_z;
        logic                    tir;
    } t_ray_out;

    // A directed row; the typed result is used only when golden is set.
    typedef struct packed {
        t_ray_in  ray;
        logic     golden;
        t_ray_out result;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic signed [W_IN-1:0] i_inc_x  = '0;
    logic signed [W_IN-1:0] i_inc_y  = '0;
    logic signed [W_IN-1:0] i_inc_z  = '0;
    logic signed [W_IN-1:0] i_norm_x = '0;
    logic signed [W_IN-1:0] i_norm_y = '0;
    logic signed [W_IN-1:0] i_norm_z = '0;
    logic        [W_IN-1:0] i_index_ratio = '0;
    logic                    o_strobe;
    logic signed [W_OUT-1:0] o_out_x;
    logic signed [W_OUT-1:0] o_out_y;
    logic signed [W_OUT-1:0] o_out_z;
    logic                    o_total_reflect;

    t_ray_out pending_refractions[$];
    t_row     directed_rows[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;

    vector_refraction_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_inc_x         (i_inc_x),
        .i_inc_y         (i_inc_y),
        .i_inc_z         (i_inc_z),
        .i_norm_x        (i_norm_x),
        .i_norm_y        (i_norm_y),
        .i_norm_z        (i_norm_z),
        .i_index_ratio   (i_index_ratio),
        .o_strobe        (o_strobe),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_total_reflect (o_total_reflect)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of the square root, found one bit at a time from the top.
    function automatic longint root_floor(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return longint'(root);
    endfunction

    // Refracted direction for one ray, at full integer precision with floor shifts.
    function automatic t_ray_out refract_ray(input t_ray_in ray);
        longint   v[3];
        longint   n[3];
        longint   eta;
        longint   dot;
        longint   d;
        longint   t;
        longint   e2;
        longint   k;
        longint   k_cap;
        longint   c;
        longint   f[3];
        t_ray_out res;
        v[0] = longint'(ray.inc_x);
        v[1] = longint'(ray.inc_y);
        v[2] = longint'(ray.inc_z);
        n[0] = longint'(ray.norm_x);
        n[1] = longint'(ray.norm_y);
        n[2] = longint'(ray.norm_z);
        eta  = longint'(ray.eta);
        dot  = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
        d    = dot >>> FRAC_BITS;
        t    = Q_ONE - ((d * d) >>> FRAC_BITS);
        if (t > (64'sd1 <<< 38)) begin
            t = 64'sd1 <<< 38;
        end else if (t < -(64'sd1 <<< 38)) begin
            t = -(64'sd1 <<< 38);
        end
        e2 = (eta * eta) >>> FRAC_BITS;
        k  = Q_ONE - ((e2 * t) >>> FRAC_BITS);
        res = '0;
        // A negative k means total internal reflection with a zero vector.
        if (k < 0) begin
            res.tir = 1'b1;
            return res;
        end
        k_cap = (64'sd1 <<< (63 - FRAC_BITS)) - 1;
        if (k > k_cap) begin
            k = k_cap;
        end
        c = ((eta * d) >>> FRAC_BITS) + root_floor(longint'(k) << FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            f[i] = (eta * v[i] - c * n[i]) >>> FRAC_BITS;
            if (f[i] > OUT_HI) begin
                f[i] = OUT_HI;
            end else if (f[i] < OUT_LO) begin
                f[i] = OUT_LO;
            end
        end
        res.out_x = W_OUT'(f[0]);
        res.out_y = W_OUT'(f[1]);
        res.out_z = W_OUT'(f[2]);
        return res;
    endfunction

    // Builds one row of the directed stimulus.
    function automatic t_row make_row(input int vx, input int vy, input int vz,
                                      input int nx, input int ny, input int nz,
                                      input int eta, input bit golden,
                                      input int gx, input int gy, input int gz,
                                      input bit gtir);
        t_row row;
        row.ray.inc_x  = W_IN'(vx);
        row.ray.inc_y  = W_IN'(vy);
        row.ray.inc_z  = W_IN'(vz);
        row.ray.norm_x = W_IN'(nx);
        row.ray.norm_y = W_IN'(ny);
        row.ray.norm_z = W_IN'(nz);
        row.ray.eta    = W_IN'(eta);
        row.golden     = golden;
        row.result.out_x = W_OUT'(gx);
        row.result.out_y = W_OUT'(gy);
        row.result.out_z = W_OUT'(gz);
        row.result.tir   = gtir;
        return row;
    endfunction

    // Picks a field value at an extreme, at zero or anywhere.
    function automatic int corner_value();
        case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Random ray: plausible geometry most often, else grazing rays, corners or noise.
    function automatic t_ray_in random_ray();
        t_ray_in ray;
        int      pick;
        int      axis;
        int      sgn;
        pick = $urandom_range(99);
        ray  = t_ray_in'({$urandom, $urandom, $urandom, $urandom});
        if (pick < 45) begin
            // Directions within the unit range and eta around one.
            ray.inc_x  = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.inc_y  = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.inc_z  = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.norm_x = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.norm_y = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.norm_z = W_IN'(int'($urandom_range(32768)) - 16384);
            ray.eta    = W_IN'($urandom_range(24576, 8192));
        end else if (pick < 60) begin
            // Axis-aligned normal with a near-perpendicular incident ray.
            axis = $urandom_range(2);
            sgn  = $urandom_range(1) ? 16384 : -16384;
            ray.norm_x = W_IN'((axis == 0) ? sgn : 0);
            ray.norm_y = W_IN'((axis == 1) ? sgn : 0);
            ray.norm_z = W_IN'((axis == 2) ? sgn : 0);
            ray.inc_x  = W_IN'((axis == 0) ? int'($urandom_range(4096)) - 2048
                                           : int'($urandom_range(32768)) - 16384);
            ray.inc_y  = W_IN'((axis == 1) ? int'($urandom_range(4096)) - 2048
                                           : int'($urandom_range(32768)) - 16384);
            ray.inc_z  = W_IN'((axis == 2) ? int'($urandom_range(4096)) - 2048
                                           : int'($urandom_range(32768)) - 16384);
            ray.eta    = W_IN'($urandom_range(65535, 16384));
        end else if (pick < 75) begin
            ray.inc_x  = W_IN'(corner_value());
            ray.inc_y  = W_IN'(corner_value());
            ray.inc_z  = W_IN'(corner_value());
            ray.norm_x = W_IN'(corner_value());
            ray.norm_y = W_IN'(corner_value());
            ray.norm_z = W_IN'(corner_value());
            ray.eta    = W_IN'(corner_value());
        end
        return ray;
    endfunction

    // Offers one transaction after a random idle gap and records its expected result.
    task automatic drive_ray(input t_row row, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_inc_x       <= row.ray.inc_x;
        i_inc_y       <= row.ray.inc_y;
        i_inc_z       <= row.ray.inc_z;
        i_norm_x      <= row.ray.norm_x;
        i_norm_y      <= row.ray.norm_y;
        i_norm_z      <= row.ray.norm_z;
        i_index_ratio <= row.ray.eta;
        // Busy only moves on the rising edge, so it is stable at the falling one.
        @(negedge i_clk);
        while (busy !== 1'b0) begin
            @(negedge i_clk);
        end
        pending_refractions.push_back(row.golden ? row.result : refract_ray(row.ray));
        @(posedge i_clk);
    endtask

    // Compares one strobed result with the oldest expectation.
    task automatic check_refraction(input t_ray_out want);
        if (o_out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, o_out_x);
            mismatch_count++;
        end
        if (o_out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, o_out_y);
            mismatch_count++;
        end
        if (o_out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, o_out_z);
            mismatch_count++;
        end
        if (o_total_reflect !== want.tir) begin
            $error("total_reflect: expected %0d, got %0d", want.tir, o_total_reflect);
            mismatch_count++;
        end
    endtask

    // Result monitor: every strobe must match a waiting expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_refractions.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatch_count++;
            end else begin
                check_refraction(pending_refractions.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: reset, the directed rows, then random phases with varied idling.
    initial begin
        int   phase_idle[PHASE_COUNT];
        int   per_phase;
        t_row rand_row;
        phase_idle = '{0, 85, 33, 0};
        per_phase  = RANDOM_ITEMS / PHASE_COUNT;

        // Rays at rest, head-on, grazing, the k = 0 boundary and just past it.
        directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, -16384, 0, 0, 16384, 16384,
                                         1, 0, 0, -16384, 0));
        directed_rows.push_back(make_row(16384, 0, 0, 0, 0, 16384, 32768, 1, 0, 0, 0, 1));
        directed_rows.push_back(make_row(16384, 0, 0, 0, 0, 16384, 16384,
                                         1, 16384, 0, 0, 0));
        directed_rows.push_back(make_row(16384, 0, 0, 0, 0, 16384, 16385, 1, 0, 0, 0, 1));
        directed_rows.push_back(make_row(0, 16384, 0, 16384, 0, 0, 0,
                                         1, -16384, 0, 0, 0));
        directed_rows.push_back(make_row(16384, 0, 0, 0, 16384, 0, 65535, 1, 0, 0, 0, 1));
        directed_rows.push_back(make_row(11585, 0, -11585, 0, 0, 16384, 32768,
                                         1, 0, 0, 0, 1));
        // Field extremes, where the outputs can saturate.
        directed_rows.push_back(make_row(-32768, -32768, -32768, -32768, -32768, -32768,
                                         65535, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(32767, 32767, 32767, 32767, 32767, 32767,
                                         65535, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(32767, 32767, 32767, -32768, -32768, -32768,
                                         65535, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                         0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(32767, -32768, 32767, -32768, 32767, -32768,
                                         65535, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-32768, 32767, -32768, 32767, -32768, 32767,
                                         1, 0, 0, 0, 0, 0));
        // Negative dot products that round toward minus infinity.
        directed_rows.push_back(make_row(-1, 0, 0, 1, 0, 0, 16384, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-3, 5, -7, 11, -13, 17, 12345, 0, 0, 0, 0, 0));
        // Oblique rays entering denser and thinner media.
        directed_rows.push_back(make_row(11585, 0, -11585, 0, 0, 16384, 12288,
                                         0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(11585, 0, -11585, 0, 0, 16384, 21845,
                                         0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(9459, -9459, -9459, 0, 16384, 0, 19661,
                                         0, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            drive_ray(directed_rows[i], 0);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            for (int i = 0; i < per_phase; i++) begin
                rand_row     = '0;
                rand_row.ray = random_ray();
                drive_ray(rand_row, phase_idle[p]);
            end
        end
        start <= 1'b0;

        // Let the pipeline drain, then report.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_refractions.size() != 0) begin
            $error("%0d transactions never produced a result", pending_refractions.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
